/* rtl/bia_pkg.sv */
// Shared types, codes and helpers for the bitmap id allocator.
// No dependencies; imported by the sequencer, the core and the testbench.
package bia_pkg;

  localparam int unsigned WORD_INDEX_BITS_DEF = 10;
  localparam int unsigned ID_W                = 15;
  localparam int unsigned CNT_W               = 16;

  localparam logic [31:0]      FULL_WORD       = 32'hffff_ffff;
  localparam logic [15:0]      LFSR_TAPS       = 16'hb400;
  localparam logic [15:0]      LFSR_SEED       = 16'h0001;
  localparam logic [15:0]      PROBE_LAST      = 16'hffff;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST = 16'd16384;

  // operation codes
  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_CHECK   = 3'd1;
  localparam logic [2:0] MODE_REQUEST = 3'd2;
  localparam logic [2:0] MODE_RELEASE = 3'd3;
  localparam logic [2:0] MODE_REPLACE = 3'd4;
  localparam logic [2:0] MODE_PREP    = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RANGE      = 3'd1;
  localparam logic [2:0] ERR_UNASSIGNED = 3'd2;
  localparam logic [2:0] ERR_FULL       = 3'd3;
  localparam logic [2:0] ERR_LIMIT      = 3'd4;

  typedef struct packed {
    logic [2:0]      mode;
    logic            old_valid;
    logic [ID_W-1:0] old_id;
    logic            new_valid;
    logic [ID_W-1:0] new_id;
  } bia_in_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            ok;
    logic [2:0]      error;
  } bia_out_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    lfsr_next = (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
  endfunction

  // report only the first error of an item
  function automatic logic [2:0] keep_first(input logic [2:0] cur, input logic [2:0] e);
    keep_first = (cur == ERR_NONE) ? e : cur;
  endfunction

endpackage

/* rtl/bia_bitmap_ram.sv */
// Bitmap storage: one write port, one read port, registered read data.
// Depends on nothing but its parameter; instantiated by the allocator top.
module bia_bitmap_ram #(
  parameter int unsigned WORD_INDEX_BITS = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [WORD_INDEX_BITS-1:0] wr_addr,
  input  logic [31:0]                wr_data,
  input  logic                       rd_en,
  input  logic [WORD_INDEX_BITS-1:0] rd_addr,
  output logic [31:0]                rd_data
);

  logic [31:0] mem [2**WORD_INDEX_BITS];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/bia_seq.sv */
// Operation sequencer: read-modify-write of bitmap words, probing, counters.
// Uses bia_pkg; drives the ports of bia_bitmap_ram.
module bia_seq
  import bia_pkg::*;
#(
  parameter int unsigned WORD_INDEX_BITS = WORD_INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bia_in_t                    in_word,
  input  logic [CNT_W-1:0]           count_limit,
  input  logic                       res_free,
  output logic                       res_valid,
  output bia_out_t                   res_word,
  output logic                       ram_wr_en,
  output logic [WORD_INDEX_BITS-1:0] ram_wr_addr,
  output logic [31:0]                ram_wr_data,
  output logic                       ram_rd_en,
  output logic [WORD_INDEX_BITS-1:0] ram_rd_addr,
  input  logic [31:0]                ram_rd_data
);

  localparam int unsigned W = WORD_INDEX_BITS;
  localparam logic [W:0]  ALL_FULL = {1'b1, {W{1'b0}}};

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_REL_RD  = 4'd2;
  localparam logic [3:0] S_REL_MOD = 4'd3;
  localparam logic [3:0] S_REQ_RD  = 4'd4;
  localparam logic [3:0] S_REQ_MOD = 4'd5;
  localparam logic [3:0] S_ALLOC   = 4'd6;
  localparam logic [3:0] S_PROBE   = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  function automatic logic [3:0] next_phase(input logic [2:0] mode, input logic new_valid);
    case (mode)
      MODE_ALLOC:   next_phase = S_ALLOC;
      MODE_CHECK,
      MODE_REQUEST,
      MODE_REPLACE: next_phase = S_REQ_RD;
      MODE_PREP:    next_phase = new_valid ? S_REQ_RD : S_ALLOC;
      default:      next_phase = S_FIN;
    endcase
  endfunction

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    logic [30:0] ext;
    ext = {16'b0, id};
    id_in_range = ((ext >> (W + 5)) == 31'd0);
  endfunction

  function automatic logic [W-1:0] word_of(input logic [ID_W-1:0] id);
    logic [30:0] ext;
    ext = {16'b0, id};
    word_of = ext[W+4:5];
  endfunction

  function automatic logic [4:0] first_zero(input logic [31:0] word);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) pos = 5'(i);
    end
    first_zero = pos;
  endfunction

  logic [3:0]       state_r, state_nxt;
  bia_in_t          item_r, item_nxt;
  logic [2:0]       err_r, err_nxt;
  logic             ok_r, ok_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;
  logic [W-1:0]     w_r, w_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [15:0]      lfsr_r, lfsr_nxt;
  logic [15:0]      tries_r, tries_nxt;
  logic             fb_r, fb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W:0]       full_cnt_r, full_cnt_nxt;
  logic [W-1:0]     clr_r, clr_nxt;

  logic [31:0]      bit_mask;
  logic [31:0]      new_word;
  logic [15:0]      lfsr_adv;
  logic [CNT_W-1:0] cnt_inc;
  logic [4:0]       pos;
  logic [W+19:0]    rid_ext;
  logic             wr_old_full;
  logic             wr_new_full;

  assign bit_mask = 32'b1 << bit_r;
  assign lfsr_adv = lfsr_next(lfsr_r);
  assign cnt_inc  = cnt_r + 16'd1;
  assign pos      = first_zero(ram_rd_data);
  assign rid_ext  = {15'b0, w_r, pos};

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_FIN) && res_free;
  assign res_word  = '{result_id: rid_r, ok: ok_r, error: err_r};

  assign wr_old_full = (ram_rd_data == FULL_WORD);
  assign wr_new_full = (new_word == FULL_WORD);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    err_nxt      = err_r;
    ok_nxt       = ok_r;
    rid_nxt      = rid_r;
    w_nxt        = w_r;
    bit_nxt      = bit_r;
    lfsr_nxt     = lfsr_r;
    tries_nxt    = tries_r;
    fb_nxt       = fb_r;
    cnt_nxt      = cnt_r;
    full_cnt_nxt = full_cnt_r;
    clr_nxt      = clr_r;
    new_word     = ram_rd_data;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = w_r;
    ram_wr_data  = new_word;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = w_r;

    case (state_r)
      S_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        ram_wr_data = 32'b0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == {W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_word;
          err_nxt  = ERR_NONE;
          ok_nxt   = 1'b0;
          rid_nxt  = (in_word.mode == MODE_PREP && in_word.new_valid) ? in_word.new_id : '0;
          if (in_word.old_valid && (in_word.mode == MODE_RELEASE ||
              in_word.mode == MODE_REPLACE || in_word.mode == MODE_PREP)) begin
            state_nxt = S_REL_RD;
          end else begin
            state_nxt = next_phase(in_word.mode, in_word.new_valid);
          end
        end
      end

      S_REL_RD: begin
        if (!id_in_range(item_r.old_id)) begin
          err_nxt   = keep_first(err_r, ERR_RANGE);
          state_nxt = next_phase(item_r.mode, item_r.new_valid);
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = word_of(item_r.old_id);
          w_nxt       = word_of(item_r.old_id);
          bit_nxt     = item_r.old_id[4:0];
          state_nxt   = S_REL_MOD;
        end
      end

      S_REL_MOD: begin
        if ((ram_rd_data & bit_mask) == 32'b0) begin
          err_nxt = keep_first(err_r, ERR_UNASSIGNED);
        end else begin
          new_word    = ram_rd_data & ~bit_mask;
          ram_wr_en   = 1'b1;
          ram_wr_data = new_word;
          cnt_nxt     = cnt_r - 16'd1;
          if (wr_old_full) begin
            full_cnt_nxt = full_cnt_r - 1'b1;
          end
        end
        state_nxt = next_phase(item_r.mode, item_r.new_valid);
      end

      S_REQ_RD: begin
        if (!item_r.new_valid || !id_in_range(item_r.new_id)) begin
          err_nxt   = keep_first(err_r, ERR_RANGE);
          state_nxt = S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = word_of(item_r.new_id);
          w_nxt       = word_of(item_r.new_id);
          bit_nxt     = item_r.new_id[4:0];
          state_nxt   = S_REQ_MOD;
        end
      end

      S_REQ_MOD: begin
        if ((ram_rd_data & bit_mask) == 32'b0) begin
          ok_nxt = 1'b1;
          if (item_r.mode != MODE_CHECK) begin
            new_word    = ram_rd_data | bit_mask;
            ram_wr_en   = 1'b1;
            ram_wr_data = new_word;
            cnt_nxt     = cnt_inc;
            if (cnt_inc > count_limit) begin
              err_nxt = keep_first(err_r, ERR_LIMIT);
            end
            if (wr_new_full) begin
              full_cnt_nxt = full_cnt_r + 1'b1;
            end
          end
        end
        state_nxt = S_FIN;
      end

      S_ALLOC: begin
        if (full_cnt_r == ALL_FULL) begin
          err_nxt   = keep_first(err_r, ERR_FULL);
          ok_nxt    = 1'b0;
          rid_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          lfsr_nxt    = lfsr_adv;
          ram_rd_en   = 1'b1;
          ram_rd_addr = lfsr_adv[W-1:0];
          w_nxt       = lfsr_adv[W-1:0];
          tries_nxt   = 16'd1;
          fb_nxt      = 1'b0;
          state_nxt   = S_PROBE;
        end
      end

      S_PROBE: begin
        if (fb_r || !wr_old_full) begin
          // take the lowest free bit of the word in hand
          new_word    = ram_rd_data | (32'b1 << pos);
          ram_wr_en   = 1'b1;
          ram_wr_data = new_word;
          cnt_nxt     = cnt_inc;
          if (cnt_inc > count_limit) begin
            err_nxt = keep_first(err_r, ERR_LIMIT);
          end
          if (wr_new_full) begin
            full_cnt_nxt = full_cnt_r + 1'b1;
          end
          rid_nxt   = rid_ext[ID_W-1:0];
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else if (tries_r == PROBE_LAST) begin
          // the LFSR has wrapped; only word zero can be left
          fb_nxt      = 1'b1;
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
          w_nxt       = '0;
        end else begin
          lfsr_nxt    = lfsr_adv;
          ram_rd_en   = 1'b1;
          ram_rd_addr = lfsr_adv[W-1:0];
          w_nxt       = lfsr_adv[W-1:0];
          tries_nxt   = tries_r + 16'd1;
        end
      end

      S_FIN: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      lfsr_r     <= LFSR_SEED;
      cnt_r      <= '0;
      full_cnt_r <= '0;
      clr_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      lfsr_r     <= lfsr_nxt;
      cnt_r      <= cnt_nxt;
      full_cnt_r <= full_cnt_nxt;
      clr_r      <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    err_r   <= err_nxt;
    ok_r    <= ok_nxt;
    rid_r   <= rid_nxt;
    w_r     <= w_nxt;
    bit_r   <= bit_nxt;
    tries_r <= tries_nxt;
    fb_r    <= fb_nxt;
  end

endmodule

/* rtl/bitmap_id_allocator_core.sv */
// Path: check and request words pass S_REQ_RD, S_REQ_MOD and S_FIN; a leading release adds
// S_REL_RD, S_REL_MOD; allocation probes on past full words (65535 LFSR probes, then word 0).
// Throughput: one word in flight; the next is accepted when its predecessor reaches the
// output register, set by the single read-modify-write path into the bitmap memory.
// Reset: clears counters, sets the LFSR to its seed, then sweeps the bitmap to zero
// with in_stall high; cfg writes are taken throughout.
module bitmap_id_allocator_core
  import bia_pkg::*;
#(
  parameter int unsigned WORD_INDEX_BITS = WORD_INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bia_in_t          in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output bia_out_t         out_word,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  logic [CNT_W-1:0]               count_limit_r;
  logic                           out_valid_r;
  bia_out_t                       out_word_r;
  logic                           res_free;
  logic                           res_valid;
  bia_out_t                       res_word;
  logic                           ram_wr_en;
  logic [WORD_INDEX_BITS-1:0]     ram_wr_addr;
  logic [31:0]                    ram_wr_data;
  logic                           ram_rd_en;
  logic [WORD_INDEX_BITS-1:0]     ram_rd_addr;
  logic [31:0]                    ram_rd_data;

  // output register frees up when empty or drained this cycle
  assign res_free = !out_valid_r || !out_stall;

  bia_seq #(
    .WORD_INDEX_BITS(WORD_INDEX_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .count_limit (count_limit_r),
    .res_free    (res_free),
    .res_valid   (res_valid),
    .res_word    (res_word),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bia_bitmap_ram #(
    .WORD_INDEX_BITS(WORD_INDEX_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= COUNT_LIMIT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_limit_r <= cfg_wr_data;
      end
      if (res_free) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* tb/tb_bitmap_id_allocator_core.sv */
// Self-checking testbench for bitmap_id_allocator_core: directed and random request words,
// each result word checked against a local model of the bitmap, the count and the probe LFSR.
// Depends on bia_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator_core;
  import bia_pkg::*;

  localparam int unsigned      IDX_BITS    = WORD_INDEX_BITS_DEF;
  localparam int unsigned      WORDS       = 1 << IDX_BITS;
  localparam int unsigned      PROBE_TRIES = 65535;
  localparam logic [2:0]       MODE_SPARE6 = 3'd6;
  localparam logic [2:0]       MODE_SPARE7 = 3'd7;
  localparam logic [CNT_W-1:0] LIMIT_MAX   = 16'd32768;
  localparam logic [ID_W-1:0]  ID_TOP      = '1;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  bia_in_t          in_word     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  bia_out_t         out_word;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  // model of the allocator
  logic [31:0]      id_map [WORDS];
  logic [CNT_W-1:0] held_count;
  logic [15:0]      probe_state;
  logic [CNT_W-1:0] limit_reg;
  logic [2:0]       step_err;

  bia_out_t         pending_outcomes [$];
  bia_out_t         last_outcome;
  logic [ID_W-1:0]  granted_ids [$];
  int unsigned      mismatch_count = 0;
  int unsigned      stall_left     = 0;
  bit               calm           = 1'b0;

  bitmap_id_allocator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_err(input logic [2:0] e);
    if (step_err == ERR_NONE) step_err = e;
  endfunction

  function automatic bit id_reachable(input logic [ID_W-1:0] id);
    return (32'(id) >> 5) < WORDS;
  endfunction

  function automatic void count_grant();
    held_count = held_count + 1'b1;
    if (held_count > limit_reg) note_err(ERR_LIMIT);
  endfunction

  function automatic void free_id(input logic [ID_W-1:0] id);
    if (!id_reachable(id)) note_err(ERR_RANGE);
    else if (!id_map[id[ID_W-1:5]][id[4:0]]) note_err(ERR_UNASSIGNED);
    else begin
      id_map[id[ID_W-1:5]][id[4:0]] = 1'b0;
      held_count = held_count - 1'b1;
    end
  endfunction

  // true if the id was free; assign it when take is set
  function automatic bit claim_id(input logic [ID_W-1:0] id, input bit take);
    if (!id_reachable(id)) begin
      note_err(ERR_RANGE);
      return 1'b0;
    end
    if (id_map[id[ID_W-1:5]][id[4:0]]) return 1'b0;
    if (take) begin
      id_map[id[ID_W-1:5]][id[4:0]] = 1'b1;
      count_grant();
    end
    return 1'b1;
  endfunction

  function automatic bit alloc_lowest(output logic [ID_W-1:0] rid);
    int unsigned first, w, tries, pos, cand;
    bit any, found;
    any   = 1'b0;
    found = 1'b0;
    first = 0;
    rid   = '0;
    for (int unsigned i = 0; i < WORDS; i++) begin
      if (!any && id_map[i] != FULL_WORD) begin
        first = i;
        any   = 1'b1;
      end
    end
    if (!any) begin
      note_err(ERR_FULL);
      return 1'b0;
    end
    // walk the LFSR until a word with room turns up; fall back to the lowest one
    w     = first;
    tries = 0;
    while (!found && tries < PROBE_TRIES) begin
      probe_state = probe_state[0] ? ((probe_state >> 1) ^ LFSR_TAPS) : (probe_state >> 1);
      cand = probe_state & (WORDS - 1);
      if (id_map[cand] != FULL_WORD) begin
        w     = cand;
        found = 1'b1;
      end
      tries++;
    end
    pos = 0;
    while (id_map[w][pos]) pos++;
    id_map[w][pos] = 1'b1;
    count_grant();
    rid = ID_W'((w << 5) + pos);
    return 1'b1;
  endfunction

  function automatic bia_out_t outcome_of(input bia_in_t w);
    bia_out_t        o;
    logic [ID_W-1:0] rid;
    bit              ok;
    rid      = '0;
    ok       = 1'b0;
    step_err = ERR_NONE;
    case (w.mode)
      MODE_ALLOC: ok = alloc_lowest(rid);
      MODE_CHECK, MODE_REQUEST: begin
        if (!w.new_valid) note_err(ERR_RANGE);
        else ok = claim_id(w.new_id, w.mode == MODE_REQUEST);
      end
      MODE_RELEASE: begin
        if (w.old_valid) free_id(w.old_id);
      end
      MODE_REPLACE: begin
        if (w.old_valid) free_id(w.old_id);
        if (!w.new_valid) note_err(ERR_RANGE);
        else ok = claim_id(w.new_id, 1'b1);
      end
      MODE_PREP: begin
        if (w.old_valid) free_id(w.old_id);
        if (!w.new_valid) ok = alloc_lowest(rid);
        else begin
          rid = w.new_id;
          ok  = claim_id(w.new_id, 1'b1);
        end
      end
      default: ;
    endcase
    o.result_id = rid;
    o.ok        = ok;
    o.error     = step_err;
    return o;
  endfunction

  function automatic bia_in_t word_of(input logic [2:0] mode, input logic ov,
                                      input logic [ID_W-1:0] oid, input logic nv,
                                      input logic [ID_W-1:0] nid);
    bia_in_t w;
    w.mode      = mode;
    w.old_valid = ov;
    w.old_id    = oid;
    w.new_valid = nv;
    w.new_id    = nid;
    return w;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && granted_ids.size() != 0)
      return granted_ids[$urandom_range(0, granted_ids.size() - 1)];
    if (r < 8) return ID_W'($urandom_range(0, 127));
    return ID_W'($urandom());
  endfunction

  function automatic bia_in_t random_word();
    bia_in_t     w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) w.mode = MODE_ALLOC;
    else if (r < 30) w.mode = MODE_CHECK;
    else if (r < 50) w.mode = MODE_REQUEST;
    else if (r < 68) w.mode = MODE_RELEASE;
    else if (r < 81) w.mode = MODE_REPLACE;
    else if (r < 95) w.mode = MODE_PREP;
    else if (r < 97) w.mode = MODE_SPARE6;
    else w.mode = MODE_SPARE7;
    w.old_valid = $urandom_range(0, 9) != 0;
    // prepare-to-replace allocates when no new id is given; make that common
    w.new_valid = $urandom_range(0, 9) > ((w.mode == MODE_PREP) ? 3 : 0);
    w.old_id    = pick_id();
    w.new_id    = pick_id();
    return w;
  endfunction

  task automatic send_word(input bia_in_t w);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_outcome = outcome_of(w);
    pending_outcomes.push_back(last_outcome);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  task automatic test_directed_modes();
    send_word(word_of(MODE_ALLOC, 1'b0, '0, 1'b0, '0));
    send_word(word_of(MODE_CHECK, 1'b0, '0, 1'b1, '0));
    send_word(word_of(MODE_CHECK, 1'b0, '0, 1'b1, ID_TOP));
    send_word(word_of(MODE_CHECK, 1'b1, ID_TOP, 1'b0, ID_TOP));
    send_word(word_of(MODE_REQUEST, 1'b0, '0, 1'b1, ID_TOP));
    send_word(word_of(MODE_REQUEST, 1'b0, '0, 1'b1, ID_TOP));
    send_word(word_of(MODE_REQUEST, 1'b0, '0, 1'b0, '0));
    send_word(word_of(MODE_RELEASE, 1'b1, ID_TOP, 1'b0, '0));
    send_word(word_of(MODE_RELEASE, 1'b1, ID_TOP, 1'b0, '0));
    send_word(word_of(MODE_RELEASE, 1'b0, ID_TOP, 1'b1, ID_TOP));
    send_word(word_of(MODE_REPLACE, 1'b1, 15'd0, 1'b1, 15'd1));
    // old id not held: release error wins, the request still goes through
    send_word(word_of(MODE_REPLACE, 1'b1, 15'd0, 1'b1, 15'd2));
    send_word(word_of(MODE_REPLACE, 1'b1, 15'd1, 1'b0, '0));
    send_word(word_of(MODE_PREP, 1'b1, 15'd2, 1'b0, '0));
    send_word(word_of(MODE_PREP, 1'b0, '0, 1'b1, 15'd300));
    send_word(word_of(MODE_PREP, 1'b0, '0, 1'b1, 15'd300));
    send_word(word_of(MODE_PREP, 1'b1, 15'd300, 1'b1, 15'd300));
    send_word(word_of(MODE_PREP, 1'b1, 15'd5000, 1'b0, '0));
    send_word(word_of(MODE_SPARE6, 1'b1, ID_TOP, 1'b1, ID_TOP));
    send_word(word_of(MODE_SPARE7, 1'b1, ID_TOP, 1'b1, ID_TOP));
    send_word(word_of(MODE_SPARE7, 1'b0, '0, 1'b0, '0));
  endtask

  task automatic test_count_limit();
    set_limit(16'd0);
    send_word(word_of(MODE_REQUEST, 1'b0, '0, 1'b1, 15'd700));
    send_word(word_of(MODE_CHECK, 1'b0, '0, 1'b1, 15'd701));
    send_word(word_of(MODE_ALLOC, 1'b0, '0, 1'b0, '0));
    send_word(word_of(MODE_RELEASE, 1'b1, 15'd700, 1'b0, '0));
    set_limit(held_count);
    send_word(word_of(MODE_REQUEST, 1'b0, '0, 1'b1, 15'd701));
    send_word(word_of(MODE_REPLACE, 1'b1, 15'd701, 1'b1, 15'd702));
    send_word(word_of(MODE_RELEASE, 1'b1, 15'd702, 1'b0, '0));
  endtask

  task automatic test_random_traffic();
    bia_in_t          w;
    logic [CNT_W-1:0] lim;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: lim = LIMIT_MAX;
        1: lim = '0;
        2: lim = CNT_W'(held_count + $urandom_range(0, 6));
        default: lim = CNT_W'($urandom_range(1, 32767));
      endcase
      calm = (p == 2);
      set_limit(lim);
      for (int n = 0; n < 163; n++) begin
        // hold off until everything in flight has come back
        if (n == 80) drain();
        w = random_word();
        send_word(w);
        if (last_outcome.ok && w.mode != MODE_CHECK) begin
          granted_ids.push_back((w.mode == MODE_REQUEST || w.mode == MODE_REPLACE) ?
                                w.new_id : last_outcome.result_id);
          if (granted_ids.size() > 64) void'(granted_ids.pop_front());
        end
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin : receiver_stall
    int unsigned n;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      n = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
      stall_left <= (n != 0) ? n - 1 : 0;
      out_stall  <= (n != 0);
    end
  end

  always @(posedge clk) begin : result_check
    bia_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_word);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_word.result_id !== want.result_id || out_word.ok !== want.ok ||
            out_word.error !== want.error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("bad result: id %0d/%0d ok %0b/%0b error %0d/%0d (expected/actual)",
                     want.result_id, out_word.result_id, want.ok, out_word.ok,
                     want.error, out_word.error);
        end
      end
    end
  end

  initial begin : watchdog
    #(40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    for (int i = 0; i < int'(WORDS); i++) id_map[i] = '0;
    held_count  = '0;
    probe_state = LFSR_SEED;
    limit_reg   = COUNT_LIMIT_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_modes();
    test_count_limit();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* bitmap_id_allocator_core.f */
rtl/bia_pkg.sv
rtl/bia_bitmap_ram.sv
rtl/bia_seq.sv
rtl/bitmap_id_allocator_core.sv
tb/tb_bitmap_id_allocator_core.sv
